// ===== rtl/bcc_pkg.sv =====
// bcc_pkg: shared constants, operation codes and the command/status structs
// for the box collision checker. Depends on nothing; every rtl file imports it.
`timescale 1ns / 1ps

package bcc_pkg;

    // Coordinate and register widths
    localparam int unsigned COORD_W = 32;
    localparam int unsigned HALF_W  = 17;
    localparam int unsigned OP_W    = 2;

    // Reset half size: 0.13 / 2.0 = 0.065 in unsigned Q1.16, rounded to nearest
    localparam logic [HALF_W-1:0] HALF_SIZE_RESET = 17'd4260;

    // Table capacities and the widths that follow from them
    localparam int unsigned MAX_OBSTACLES   = 16;
    localparam int unsigned MAX_WALL_POINTS = 1024;
    localparam int unsigned OBS_AW  = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int unsigned OBS_CW  = $clog2(MAX_OBSTACLES + 1);
    localparam int unsigned WALL_AW = (MAX_WALL_POINTS > 1) ? $clog2(MAX_WALL_POINTS) : 1;
    localparam int unsigned WALL_CW = $clog2(MAX_WALL_POINTS + 1);
    localparam int unsigned IDX_W   = (OBS_CW > WALL_CW) ? OBS_CW : WALL_CW;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_OBS  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_WALL = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;    // latch the incoming item
        logic clear;      // empty both tables
        logic wr_obs;     // store an obstacle box
        logic wr_wall;    // store a wall point
        logic scan_init;  // reset scan index and flags
        logic issue;      // read the tables at the scan index
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_end;
    } t_status;

endpackage

// ===== rtl/bcc_dpath.sv =====
// bcc_dpath: item registers, obstacle and wall point memories, table counts,
// scan index and the overlap compare/accumulate. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_dpath import bcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [COORD_W-1:0] i_x_min_or_point,
    input  logic signed [COORD_W-1:0] i_x_max,
    input  logic signed [COORD_W-1:0] i_y_min_or_point,
    input  logic signed [COORD_W-1:0] i_y_max,
    input  logic                      i_cfg_wr,
    input  logic [HALF_W-1:0]         i_cfg_data,
    output logic                      o_obstacle_clear,
    output logic                      o_wall_clear
);

    // Saturate a 33-bit signed sum back into the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W:0] v);
        logic signed [COORD_W-1:0] res;
        if (v[COORD_W] != v[COORD_W-1]) begin
            res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic [HALF_W-1:0]         r_half;
    logic [OP_W-1:0]           r_op;
    logic signed [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [OBS_CW-1:0]         r_obs_held;
    logic [WALL_CW-1:0]        r_wall_held;
    logic [IDX_W-1:0]          r_idx;
    logic [IDX_W-1:0]          scan_len;
    logic                      r_v_obs, r_v_wall;
    logic                      r_obs_clr, r_wall_clr;

    logic [4*COORD_W-1:0]      r_obs_mem  [MAX_OBSTACLES];
    logic [2*COORD_W-1:0]      r_wall_mem [MAX_WALL_POINTS];
    logic [4*COORD_W-1:0]      r_obs_rd;
    logic [2*COORD_W-1:0]      r_wall_rd;

    logic signed [COORD_W:0]   half_ext;
    logic signed [COORD_W-1:0] bx0, bx1, by0, by1, px, py;
    logic                      obs_hit, wall_hit;
    logic                      obs_full, wall_full;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_SIZE_RESET;
        end else if (i_cfg_wr) begin
            r_half <= i_cfg_data;
        end
    end

    // Hold the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_x0 <= i_x_min_or_point;
            r_x1 <= i_x_max;
            r_y0 <= i_y_min_or_point;
            r_y1 <= i_y_max;
        end
    end

    assign half_ext  = signed'({{(COORD_W+1-HALF_W){1'b0}}, r_half});
    assign obs_full  = (r_obs_held == OBS_CW'(MAX_OBSTACLES));
    assign wall_full = (r_wall_held == WALL_CW'(MAX_WALL_POINTS));

    // Table counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_held  <= '0;
            r_wall_held <= '0;
        end else if (i_cmd.clear) begin
            r_obs_held  <= '0;
            r_wall_held <= '0;
        end else begin
            if (i_cmd.wr_obs && !obs_full) begin
                r_obs_held <= r_obs_held + 1'b1;
            end
            if (i_cmd.wr_wall && !wall_full) begin
                r_wall_held <= r_wall_held + 1'b1;
            end
        end
    end

    // Obstacle memory: store the box bounds, read at the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_obs && !obs_full) begin
            r_obs_mem[r_obs_held[OBS_AW-1:0]] <= {
                sat_coord({r_x0[COORD_W-1], r_x0} - half_ext),
                sat_coord({r_x0[COORD_W-1], r_x0} + half_ext),
                sat_coord({r_y0[COORD_W-1], r_y0} - half_ext),
                sat_coord({r_y0[COORD_W-1], r_y0} + half_ext)};
        end
        r_obs_rd <= r_obs_mem[r_idx[OBS_AW-1:0]];
    end

    // Wall point memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_wall && !wall_full) begin
            r_wall_mem[r_wall_held[WALL_AW-1:0]] <= {r_x0, r_y0};
        end
        r_wall_rd <= r_wall_mem[r_idx[WALL_AW-1:0]];
    end

    // Scan length is the larger of the two counts
    always_comb begin
        if (IDX_W'(r_obs_held) > IDX_W'(r_wall_held)) begin
            scan_len = IDX_W'(r_obs_held);
        end else begin
            scan_len = IDX_W'(r_wall_held);
        end
    end

    // Advance the scan index and mark which read data is live
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_v_obs  <= 1'b0;
            r_v_wall <= 1'b0;
        end else begin
            r_v_obs  <= i_cmd.issue && (r_idx < IDX_W'(r_obs_held));
            r_v_wall <= i_cmd.issue && (r_idx < IDX_W'(r_wall_held));
            if (i_cmd.scan_init) begin
                r_idx <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Strict overlap compares against the registered read data
    assign bx0 = r_obs_rd[4*COORD_W-1:3*COORD_W];
    assign bx1 = r_obs_rd[3*COORD_W-1:2*COORD_W];
    assign by0 = r_obs_rd[2*COORD_W-1:COORD_W];
    assign by1 = r_obs_rd[COORD_W-1:0];
    assign px  = r_wall_rd[2*COORD_W-1:COORD_W];
    assign py  = r_wall_rd[COORD_W-1:0];

    assign obs_hit  = (r_x0 < bx1) && (bx0 < r_x1) && (r_y0 < by1) && (by0 < r_y1);
    assign wall_hit = (r_x0 < px) && (px < r_x1) && (r_y0 < py) && (py < r_y1);

    // Drop the clear flags on any live hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_clr  <= 1'b1;
            r_wall_clr <= 1'b1;
        end else if (i_cmd.scan_init) begin
            r_obs_clr  <= 1'b1;
            r_wall_clr <= 1'b1;
        end else begin
            if (r_v_obs && obs_hit) begin
                r_obs_clr <= 1'b0;
            end
            if (r_v_wall && wall_hit) begin
                r_wall_clr <= 1'b0;
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.scan_end = (r_idx == scan_len);
    assign o_obstacle_clear  = r_obs_clr;
    assign o_wall_clear      = r_wall_clr;

    a_obs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_obs_held <= OBS_CW'(MAX_OBSTACLES))
        else $error("obstacle count beyond capacity");

    a_wall_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wall_held <= WALL_CW'(MAX_WALL_POINTS))
        else $error("wall point count beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_obs_held == '0) && (r_wall_held == '0))
        else $error("clear left entries in a table");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_obs && obs_full && !i_cmd.clear) |=> $stable(r_obs_held))
        else $error("load into a full obstacle table changed the count");

endmodule

// ===== rtl/bcc_ctrl.sv =====
// bcc_ctrl: sequencer for one item at a time: accept, execute and, for a query,
// table scan, pipeline drain and the result strobe. Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_ctrl import bcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_strobe
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (i_status.op)
                    OP_CLEAR:     o_cmd.clear   = 1'b1;
                    OP_LOAD_OBS:  o_cmd.wr_obs  = 1'b1;
                    OP_LOAD_WALL: o_cmd.wr_wall = 1'b1;
                    OP_QUERY: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_strobe_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == S_DRAIN)
        else $error("result strobe without a finished scan");

    a_issue_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> !o_cmd.capture && !o_cmd.wr_obs && !o_cmd.wr_wall)
        else $error("table read overlaps an item write");

endmodule

// ===== rtl/box_collision_checker.sv =====
// box_collision_checker: top level joining the controller and the datapath.
// Depends on bcc_pkg, bcc_ctrl and bcc_dpath.
//
//   Channel   Handshake                      Payload
//   command   start in, busy out             i_op, i_x_min_or_point, i_x_max,
//                                            i_y_min_or_point, i_y_max
//   config    i_cfg_valid in, o_cfg_ready    i_cfg_data (half size, Q1.16)
//   result    o_valid out (one-cycle strobe) o_obstacle_clear, o_wall_clear
//
// A clear or a load is accepted in idle, done in exec, and then busy falls.
// A query passes exec and scans N entries, N being the larger of the two table
// counts: the scan reads one obstacle and one wall point a cycle from the two
// memories, then drains the read register before the result strobe.
// Reset is synchronous and active low; it empties both tables and restores
// the default half size. The receiver cannot stall: o_valid is one cycle.
`timescale 1ns / 1ps

module box_collision_checker import bcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_op,
    input  logic signed [COORD_W-1:0] i_x_min_or_point,
    input  logic signed [COORD_W-1:0] i_x_max,
    input  logic signed [COORD_W-1:0] i_y_min_or_point,
    input  logic signed [COORD_W-1:0] i_y_max,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [HALF_W-1:0]         i_cfg_data,
    output logic                      o_valid,
    output logic                      o_obstacle_clear,
    output logic                      o_wall_clear
);

    t_cmd    cmd;
    t_status status;

    // Take configuration only while no item is in flight
    assign o_cfg_ready = !busy;

    bcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_valid)
    );

    bcc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_op             (i_op),
        .i_x_min_or_point (i_x_min_or_point),
        .i_x_max          (i_x_max),
        .i_y_min_or_point (i_y_min_or_point),
        .i_y_max          (i_y_max),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_obstacle_clear (o_obstacle_clear),
        .o_wall_clear     (o_wall_clear)
    );

endmodule
